// ===== src/tzphc_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-zone polygon hit classifier: shared definitions
// Sizes, command and level codes, and the types that pass between the
// vertex memories, the edge units and the sequencer.
// ----------------------------------------------------------------------------
package tzphc_pkg;

   localparam int MAX_VERTICES      = 16;
   localparam int COORD_BITS        = 24;
   localparam int MIN_POLY_VERTICES = 3;

   localparam int ADDR_BITS  = $clog2(MAX_VERTICES);
   localparam int STEP_BITS  = $clog2(MAX_VERTICES + 1);
   localparam int INDEX_BITS = 4;
   localparam int COUNT_BITS = 5;
   localparam int VERTEX_BITS = 2 * COORD_BITS;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;

   localparam int REQ_FIELD_BITS = INDEX_BITS + 2 * COORD_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int REQ_USER_BITS  = 2;
   localparam int RSP_DATA_BITS  = 8;
   localparam int LEVEL_BITS     = 2;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [REQ_USER_BITS-1:0] {
      CMD_LOAD_STOP = 2'd0,
      CMD_LOAD_SLOW = 2'd1,
      CMD_TEST      = 2'd2,
      CMD_END_FRAME = 2'd3
   } cmd_type;

   localparam logic [CSR_INDEX_BITS-1:0] REG_STOP_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOW_COUNT = 2'd1;

   localparam logic [LEVEL_BITS-1:0] LEVEL_SAFE = 2'd0;
   localparam logic [LEVEL_BITS-1:0] LEVEL_STOP = 2'd1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_SLOW = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      logic valid;
      logic first;
   } edge_step_type;

endpackage

// ===== src/tzphc_vertex_ram.sv =====
// ----------------------------------------------------------------------------
// Vertex memory
// One polygon's vertex slots, each an x,y pair, with one write port and one
// read port whose data is registered.
// ----------------------------------------------------------------------------
module tzphc_vertex_ram (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [tzphc_pkg::ADDR_BITS-1:0]        wr_addr,
   input  logic [tzphc_pkg::VERTEX_BITS-1:0]      wr_data,
   input  logic                                   rd_en,
   input  logic [tzphc_pkg::ADDR_BITS-1:0]        rd_addr,
   output logic [tzphc_pkg::VERTEX_BITS-1:0]      rd_data
);

   logic [tzphc_pkg::VERTEX_BITS-1:0] mem [tzphc_pkg::MAX_VERTICES];
   logic [tzphc_pkg::VERTEX_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tzphc_edge_unit.sv =====
// ----------------------------------------------------------------------------
// Edge crossing unit
// Takes one polygon's vertices in walk order, forms each edge with the
// vertex before it and keeps the even-odd crossing parity for the point.
// ----------------------------------------------------------------------------
module tzphc_edge_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  tzphc_pkg::edge_step_type            step,
   input  logic [tzphc_pkg::VERTEX_BITS-1:0]   vertex,
   input  tzphc_pkg::coord_type                point_x,
   input  tzphc_pkg::coord_type                point_y,
   output logic                                busy,
   output logic                                hit
);

   tzphc_pkg::edge_step_type s0_ff, s0_in;
   tzphc_pkg::coord_type     cur_x, cur_y;
   tzphc_pkg::coord_type     prev_x_ff, prev_y_ff;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_cross_ff, s1_rise_ff;
   tzphc_pkg::diff_type      s1_dx_ff, s1_dy_ff, s1_u_ff, s1_v_ff;
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_cross_ff, s2_rise_ff;
   tzphc_pkg::prod_type      s2_lhs_ff, s2_rhs_ff;
   logic                     left;
   logic                     hit_ff, hit_in;

   assign cur_x = tzphc_pkg::coord_type'(vertex[tzphc_pkg::COORD_BITS-1:0]);
   assign cur_y = tzphc_pkg::coord_type'(vertex[tzphc_pkg::VERTEX_BITS-1:tzphc_pkg::COORD_BITS]);

   always_comb begin
      s0_in       = start ? '0 : step;
      s1_valid_in = !start && s0_ff.valid && !s0_ff.first;
      s2_valid_in = !start && s1_valid_ff;
      left        = s2_rise_ff ? (s2_lhs_ff < s2_rhs_ff) : (s2_rhs_ff < s2_lhs_ff);
      hit_in      = hit_ff;
      if (start) begin
         hit_in = 1'b0;
      end else if (s2_valid_ff && s2_cross_ff && left) begin
         hit_in = !hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff       <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         s0_ff       <= s0_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         hit_ff      <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ff.valid) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end
      s1_cross_ff <= (cur_y > point_y) != (prev_y_ff > point_y);
      s1_rise_ff  <= prev_y_ff > cur_y;
      s1_dy_ff    <= tzphc_pkg::diff_type'(prev_y_ff) - tzphc_pkg::diff_type'(cur_y);
      s1_dx_ff    <= tzphc_pkg::diff_type'(prev_x_ff) - tzphc_pkg::diff_type'(cur_x);
      s1_u_ff     <= tzphc_pkg::diff_type'(point_x) - tzphc_pkg::diff_type'(cur_x);
      s1_v_ff     <= tzphc_pkg::diff_type'(point_y) - tzphc_pkg::diff_type'(cur_y);
      s2_cross_ff <= s1_cross_ff;
      s2_rise_ff  <= s1_rise_ff;
      s2_lhs_ff   <= tzphc_pkg::prod_type'(s1_u_ff) * tzphc_pkg::prod_type'(s1_dy_ff);
      s2_rhs_ff   <= tzphc_pkg::prod_type'(s1_dx_ff) * tzphc_pkg::prod_type'(s1_v_ff);
   end

   assign busy = s0_ff.valid || s1_valid_ff || s2_valid_ff;
   assign hit  = hit_ff;

endmodule

// ===== src/two_zone_polygon_hit_classifier_top.sv =====
// ----------------------------------------------------------------------------
// Two-zone polygon hit classifier
//
// Channel  Direction  Beat carries
// req_     in         tuser: cmd; tdata: vertex_index, coord_x, coord_y
// rsp_     out        tdata: safety_level (one beat per end of frame)
// csr_     in         index and data of a vertex count register
//
// A test point reads the vertices of both zones through the
// single read port of each zone's vertex memory, then drains the
// edge pipelines.
// Reset is synchronous and clears control state; vertex slots hold nothing
// useful until loaded, and no clearing pass runs. An end-of-frame beat
// waits while an earlier verdict has not yet been taken.
// ----------------------------------------------------------------------------
module two_zone_polygon_hit_classifier_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // Bits from 0: vertex_index[3:0], coord_x[27:4], coord_y[51:28], zeros.
   input  logic [tzphc_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // Bits from 0: cmd[1:0].
   input  logic [tzphc_pkg::REQ_USER_BITS-1:0]     req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // Bits from 0: safety_level[1:0], zeros.
   output logic [tzphc_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tzphc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tzphc_pkg::COUNT_BITS-1:0]        csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   localparam int IB = tzphc_pkg::INDEX_BITS;
   localparam int CB = tzphc_pkg::COORD_BITS;

   state_type                               state_ff, state_in;
   logic [tzphc_pkg::STEP_BITS-1:0]         step_ff, step_in;
   logic [tzphc_pkg::COUNT_BITS-1:0]        stop_count_ff, slow_count_ff;
   logic [tzphc_pkg::LEVEL_BITS-1:0]        level_ff, level_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [tzphc_pkg::LEVEL_BITS-1:0]        rsp_level_ff, rsp_level_in;
   tzphc_pkg::coord_type                    point_x_ff, point_y_ff;

   tzphc_pkg::cmd_type                      cmd;
   logic [IB-1:0]                           req_index;
   tzphc_pkg::coord_type                    req_x, req_y;
   logic                                    accept, load_ok, test_accept, eof_accept;
   logic                                    stop_we, slow_we;
   logic [tzphc_pkg::STEP_BITS-1:0]         n_stop, n_slow, last_step;
   tzphc_pkg::edge_step_type                stop_step, slow_step;
   logic [tzphc_pkg::ADDR_BITS-1:0]         stop_addr, slow_addr;
   logic [tzphc_pkg::VERTEX_BITS-1:0]       stop_rdata, slow_rdata;
   logic                                    stop_busy, slow_busy, stop_hit, slow_hit;

   function automatic logic [tzphc_pkg::STEP_BITS-1:0] active_count(
      input logic [tzphc_pkg::COUNT_BITS-1:0] count);
      int n;
      n = int'(count);
      if (n > tzphc_pkg::MAX_VERTICES) begin
         n = tzphc_pkg::MAX_VERTICES;
      end
      if (n < tzphc_pkg::MIN_POLY_VERTICES) begin
         n = 0;
      end
      return tzphc_pkg::STEP_BITS'(n);
   endfunction

   function automatic logic [tzphc_pkg::ADDR_BITS-1:0] walk_addr(
      input logic [tzphc_pkg::STEP_BITS-1:0] k,
      input logic [tzphc_pkg::STEP_BITS-1:0] n);
      logic [tzphc_pkg::STEP_BITS-1:0] a;
      a = (k == '0) ? n - 1'b1 : k - 1'b1;
      return a[tzphc_pkg::ADDR_BITS-1:0];
   endfunction

   assign cmd       = tzphc_pkg::cmd_type'(req_tuser);
   assign req_index = req_tdata[IB-1:0];
   assign req_x     = tzphc_pkg::coord_type'(req_tdata[IB+CB-1:IB]);
   assign req_y     = tzphc_pkg::coord_type'(req_tdata[IB+2*CB-1:IB+CB]);

   assign req_tready  = (state_ff == ST_IDLE) &&
                        ((cmd != tzphc_pkg::CMD_END_FRAME) || !rsp_valid_ff || rsp_tready);
   assign accept      = req_tvalid && req_tready;
   assign load_ok     = int'(req_index) < tzphc_pkg::MAX_VERTICES;
   assign stop_we     = accept && (cmd == tzphc_pkg::CMD_LOAD_STOP) && load_ok;
   assign slow_we     = accept && (cmd == tzphc_pkg::CMD_LOAD_SLOW) && load_ok;
   assign test_accept = accept && (cmd == tzphc_pkg::CMD_TEST);
   assign eof_accept  = accept && (cmd == tzphc_pkg::CMD_END_FRAME);

   assign n_stop    = active_count(stop_count_ff);
   assign n_slow    = active_count(slow_count_ff);
   assign last_step = (n_stop > n_slow) ? n_stop : n_slow;

   always_comb begin
      stop_step.valid = (state_ff == ST_WALK) && (n_stop != '0) && (step_ff <= n_stop);
      stop_step.first = step_ff == '0;
      slow_step.valid = (state_ff == ST_WALK) && (n_slow != '0) && (step_ff <= n_slow);
      slow_step.first = step_ff == '0;
      stop_addr       = walk_addr(step_ff, n_stop);
      slow_addr       = walk_addr(step_ff, n_slow);
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_level_in = rsp_level_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (test_accept) begin
               state_in = ST_WALK;
            end
            if (eof_accept) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               level_in     = tzphc_pkg::LEVEL_SAFE;
            end
         end
         ST_WALK: begin
            step_in = step_ff + 1'b1;
            if (step_ff == last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stop_busy && !slow_busy) begin
               state_in = ST_IDLE;
               if (stop_hit) begin
                  level_in = tzphc_pkg::LEVEL_STOP;
               end else if (slow_hit && (level_ff == tzphc_pkg::LEVEL_SAFE)) begin
                  level_in = tzphc_pkg::LEVEL_SLOW;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         level_ff      <= tzphc_pkg::LEVEL_SAFE;
         rsp_valid_ff  <= 1'b0;
         stop_count_ff <= '0;
         slow_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && (csr_index == tzphc_pkg::REG_STOP_COUNT)) begin
            stop_count_ff <= csr_data;
         end
         if (csr_valid && (csr_index == tzphc_pkg::REG_SLOW_COUNT)) begin
            slow_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_level_ff <= rsp_level_in;
      if (test_accept) begin
         point_x_ff <= req_x;
         point_y_ff <= req_y;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tzphc_pkg::RSP_DATA_BITS'(rsp_level_ff);

   tzphc_vertex_ram u_stop_ram (
      .clock   (clock),
      .wr_en   (stop_we),
      .wr_addr (req_index[tzphc_pkg::ADDR_BITS-1:0]),
      .wr_data ({req_y, req_x}),
      .rd_en   (stop_step.valid),
      .rd_addr (stop_addr),
      .rd_data (stop_rdata)
   );

   tzphc_vertex_ram u_slow_ram (
      .clock   (clock),
      .wr_en   (slow_we),
      .wr_addr (req_index[tzphc_pkg::ADDR_BITS-1:0]),
      .wr_data ({req_y, req_x}),
      .rd_en   (slow_step.valid),
      .rd_addr (slow_addr),
      .rd_data (slow_rdata)
   );

   tzphc_edge_unit u_stop_edges (
      .clock   (clock),
      .reset   (reset),
      .start   (test_accept),
      .step    (stop_step),
      .vertex  (stop_rdata),
      .point_x (point_x_ff),
      .point_y (point_y_ff),
      .busy    (stop_busy),
      .hit     (stop_hit)
   );

   tzphc_edge_unit u_slow_edges (
      .clock   (clock),
      .reset   (reset),
      .start   (test_accept),
      .step    (slow_step),
      .vertex  (slow_rdata),
      .point_x (point_x_ff),
      .point_y (point_y_ff),
      .busy    (slow_busy),
      .hit     (slow_hit)
   );

   a_eof_emits : assert property (@(posedge clock) disable iff (reset)
      eof_accept |=> rsp_valid_ff && (level_ff == tzphc_pkg::LEVEL_SAFE))
      else $error("end of frame did not post a verdict and clear the level");

   a_load_idle : assert property (@(posedge clock) disable iff (reset)
      (stop_we || slow_we) |-> (state_ff == ST_IDLE) && !stop_step.valid && !slow_step.valid)
      else $error("vertex write overlaps a walk");

   a_level_code : assert property (@(posedge clock) disable iff (reset)
      (level_ff == tzphc_pkg::LEVEL_SAFE) || (level_ff == tzphc_pkg::LEVEL_STOP) ||
      (level_ff == tzphc_pkg::LEVEL_SLOW))
      else $error("frame level holds an unused code");

   a_stop_sticky : assert property (@(posedge clock) disable iff (reset)
      (level_ff == tzphc_pkg::LEVEL_STOP) && !eof_accept |=> level_ff == tzphc_pkg::LEVEL_STOP)
      else $error("stop level left without an end of frame");

endmodule
